// ===== sv/catmull_rom_curve_sampler_top_defines.svh =====
// assertion macros shared by the checker
`ifndef CATMULL_ROM_CURVE_SAMPLER_TOP_DEFINES_SVH
`define CATMULL_ROM_CURVE_SAMPLER_TOP_DEFINES_SVH

// checked only while out of reset
`define CRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/crs_pkg.sv =====
package crs_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int MAX_SAMPLES_DEF = 64;

  localparam int T_FRAC   = 16;
  localparam int ACC_FRAC = 10;
  localparam int OUT_SHIFT = 3;

  localparam int TSTEP_W = 16;
  localparam logic [TSTEP_W-1:0] TSTEP_RESET = 16'd1024;

  localparam int SAMPLE_W    = 26;
  localparam int OUT_TDATA_W = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_MAX     = 33554431;
  localparam int OUT_MIN     = -33554432;

  localparam logic [1:0] WIN_FULL = 2'd3;

  typedef struct packed {
    logic              wr;
    logic [1:0]        wr_idx;
    logic              shift;
    logic              issue;
    logic              last;
    logic [T_FRAC-1:0] t;
  } crs_cmd_t;

  typedef struct packed {
    logic en;
    logic busy;
  } crs_sts_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } crs_state_t;

endpackage

// ===== sv/catmull_rom_curve_sampler_top.sv =====
// first sample: closing point beat enters RUN, then m1, m2, m3 and sample registers
// throughput: one sample per cycle from a 4-stage multiply pipeline per coordinate,
//   unless out_tready stalls it; a closing point yields ceil(65536 / step) samples
// next point is taken only once the pipeline and output register have drained
// reset: rst_n synchronous active low, clears window count, pipeline valids, t_step to 1024
module catmull_rom_curve_sampler_top #(
  parameter int COORD_BITS  = crs_pkg::COORD_BITS_DEF,
  parameter int MAX_SAMPLES = crs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // point_x, point_y
  input  logic [((2 * COORD_BITS + 7) / 8) * 8-1:0] in_tdata,
  // restart
  input  logic                                      in_tuser,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // sample_x, sample_y
  output logic [crs_pkg::OUT_TDATA_W-1:0]           out_tdata,
  output logic                                      out_tlast,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  input  logic [crs_pkg::TSTEP_W-1:0]               cfg_data,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready
);
  import crs_pkg::*;

  crs_cmd_t cmd;
  crs_sts_t sts;

  logic signed [COORD_BITS-1:0] point_x, point_y;
  logic signed [SAMPLE_W-1:0]   sample_x, sample_y;

  assign point_x = in_tdata[COORD_BITS-1:0];
  assign point_y = in_tdata[2*COORD_BITS-1:COORD_BITS];

  crs_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_restart (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

  crs_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sample_x   (sample_x),
    .sample_y   (sample_y),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W - 2 * SAMPLE_W){1'b0}}, sample_y, sample_x};

endmodule

// ===== sv/crs_ctrl.sv =====
module crs_ctrl #(
  parameter int MAX_SAMPLES = crs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_restart,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [crs_pkg::TSTEP_W-1:0]  cfg_data,
  output crs_pkg::crs_cmd_t            cmd,
  input  crs_pkg::crs_sts_t            sts
);
  import crs_pkg::*;

  localparam int MIN_STEP = (2 ** T_FRAC + MAX_SAMPLES - 1) / MAX_SAMPLES;
  localparam logic [T_FRAC:0] MIN_STEP_V = (T_FRAC + 1)'(MIN_STEP);

  crs_state_t           state_r, state_nxt;
  logic [1:0]           held_r, held_nxt;
  logic [T_FRAC-1:0]    t_r, t_nxt;
  logic [TSTEP_W-1:0]   tstep_r, tstep_nxt;

  logic [1:0]           eff_held;
  logic                 full;
  logic                 acc;
  logic [T_FRAC:0]      step_eff;
  logic [T_FRAC:0]      sum;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    t_nxt     = t_r;
    tstep_nxt = tstep_r;
    cmd       = '0;

    eff_held = in_restart ? 2'd0 : held_r;
    full     = (eff_held == WIN_FULL);
    acc      = in_tvalid && in_tready;
    step_eff = ({1'b0, tstep_r} < MIN_STEP_V) ? MIN_STEP_V : {1'b0, tstep_r};
    sum      = {1'b0, t_r} + step_eff;

    cmd.wr_idx = eff_held;
    cmd.t      = t_r;

    if (cfg_valid) begin
      tstep_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (full) begin
            cmd.shift = 1'b1;
            t_nxt     = '0;
            state_nxt = S_RUN;
          end else begin
            cmd.wr   = 1'b1;
            held_nxt = eff_held + 2'd1;
          end
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        cmd.last  = sum[T_FRAC];
        if (sts.en) begin
          t_nxt = sum[T_FRAC-1:0];
          if (sum[T_FRAC]) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      t_r     <= '0;
      tstep_r <= TSTEP_RESET;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      t_r     <= t_nxt;
      tstep_r <= tstep_nxt;
    end
  end

endmodule

// ===== sv/crs_lane.sv =====
module crs_lane #(
  parameter int COORD_BITS = crs_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                wr,
  input  logic [1:0]                          wr_idx,
  input  logic                                shift,
  input  logic                                en,
  input  logic signed [COORD_BITS-1:0]        pt,
  input  logic [crs_pkg::T_FRAC-1:0]          t,
  output logic signed [crs_pkg::SAMPLE_W-1:0] sample
);
  import crs_pkg::*;

  localparam int CW = COORD_BITS + 4;
  localparam int HW = (COORD_BITS + 16 > 28) ? COORD_BITS + 16 : 28;
  localparam int PW = HW + T_FRAC + 1;

  localparam logic signed [PW-1:0] RND_T   = PW'(2 ** (T_FRAC - 1));
  localparam logic signed [HW-1:0] RND_OUT = HW'(2 ** (OUT_SHIFT - 1));
  localparam logic signed [HW-1:0] SAT_MAX = HW'(OUT_MAX);
  localparam logic signed [HW-1:0] SAT_MIN = HW'(OUT_MIN);

  logic signed [COORD_BITS-1:0] w_r [3];

  logic signed [HW-1:0] ca_r, cb_r, cc_r, cd_r;
  logic signed [HW-1:0] ca_nxt, cb_nxt, cc_nxt, cd_nxt;
  logic [T_FRAC-1:0]    t1_r, t2_r;
  logic signed [PW-1:0] m1_r, m2_r, m3_r;
  logic signed [PW-1:0] m1_nxt, m2_nxt, m3_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;

  logic signed [CW-1:0] e0, e1, e2, e3;
  logic signed [CW-1:0] ka, kb, kc, kd;
  logic signed [T_FRAC:0] t0s, t1s, t2s;
  logic signed [HW-1:0] h1, h2, h3, r;

  always_comb begin
    e0 = CW'(w_r[0]);
    e1 = CW'(w_r[1]);
    e2 = CW'(w_r[2]);
    e3 = CW'(pt);
    ka = e1 <<< 1;
    kb = e2 - e0;
    kc = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    kd = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
    ca_nxt = HW'(ka) <<< ACC_FRAC;
    cb_nxt = HW'(kb) <<< ACC_FRAC;
    cc_nxt = HW'(kc) <<< ACC_FRAC;
    cd_nxt = HW'(kd) <<< ACC_FRAC;

    t0s = signed'({1'b0, t});
    t1s = signed'({1'b0, t1_r});
    t2s = signed'({1'b0, t2_r});

    // horner, one multiply per stage
    m1_nxt = cd_r * t0s;
    h1     = cc_r + HW'((m1_r + RND_T) >>> T_FRAC);
    m2_nxt = h1 * t1s;
    h2     = cb_r + HW'((m2_r + RND_T) >>> T_FRAC);
    m3_nxt = h2 * t2s;
    h3     = ca_r + HW'((m3_r + RND_T) >>> T_FRAC);
    r      = (h3 + RND_OUT) >>> OUT_SHIFT;

    if (r > SAT_MAX) begin
      sample_nxt = SAMPLE_W'(OUT_MAX);
    end else if (r < SAT_MIN) begin
      sample_nxt = SAMPLE_W'(OUT_MIN);
    end else begin
      sample_nxt = r[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ca_r   <= ca_nxt;
      cb_r   <= cb_nxt;
      cc_r   <= cc_nxt;
      cd_r   <= cd_nxt;
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      w_r[2] <= pt;
    end else if (wr) begin
      w_r[wr_idx] <= pt;
    end
    if (en) begin
      t1_r     <= t;
      t2_r     <= t1_r;
      m1_r     <= m1_nxt;
      m2_r     <= m2_nxt;
      m3_r     <= m3_nxt;
      sample_r <= sample_nxt;
    end
  end

  assign sample = sample_r;

endmodule

// ===== sv/crs_dp.sv =====
module crs_dp #(
  parameter int COORD_BITS = crs_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crs_pkg::crs_cmd_t                   cmd,
  output crs_pkg::crs_sts_t                   sts,
  input  logic signed [COORD_BITS-1:0]        point_x,
  input  logic signed [COORD_BITS-1:0]        point_y,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [crs_pkg::SAMPLE_W-1:0] sample_x,
  output logic signed [crs_pkg::SAMPLE_W-1:0] sample_y,
  output logic                                out_tlast
);
  import crs_pkg::*;

  localparam int STAGES = 4;

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic [STAGES-1:0] lst_r, lst_nxt;
  logic              en;

  // whole pipe stalls while the output beat waits
  assign en       = !vld_r[STAGES-1] || out_tready;
  assign sts.en   = en;
  assign sts.busy = |vld_r;

  always_comb begin
    vld_nxt = vld_r;
    lst_nxt = lst_r;
    if (en) begin
      vld_nxt = {vld_r[STAGES-2:0], cmd.issue};
      lst_nxt = {lst_r[STAGES-2:0], cmd.last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    lst_r <= lst_nxt;
  end

  crs_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
    .clk    (clk),
    .wr     (cmd.wr),
    .wr_idx (cmd.wr_idx),
    .shift  (cmd.shift),
    .en     (en),
    .pt     (point_x),
    .t      (cmd.t),
    .sample (sample_x)
  );

  crs_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
    .clk    (clk),
    .wr     (cmd.wr),
    .wr_idx (cmd.wr_idx),
    .shift  (cmd.shift),
    .en     (en),
    .pt     (point_y),
    .t      (cmd.t),
    .sample (sample_y)
  );

  assign out_tvalid = vld_r[STAGES-1];
  assign out_tlast  = lst_r[STAGES-1];

endmodule

// ===== sv/crs_chk.sv =====
`include "catmull_rom_curve_sampler_top_defines.svh"

module crs_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic                           out_tlast,
  input logic [crs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `CRS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "out beat dropped")
  `CRS_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "stalled out beat changed")
  `CRS_ASSERT(a_idle_empty, clk, rst_n, in_tready |-> !out_tvalid, "input ready with output pending")
  `CRS_ASSERT(a_last_gap, clk, rst_n, out_tvalid && out_tready && out_tlast |=> !out_tvalid, "beat after segment end")
  `CRS_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind catmull_rom_curve_sampler_top crs_chk u_crs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tdata  (out_tdata)
);
